### hdl/prqs_pkg.sv
// Shared types and constants for the priority ready queue scheduler.
// No dependencies.
`timescale 1ns / 1ps
package prqs_pkg;
    typedef enum logic [2:0] {
        OP_ADD_TAIL = 3'd0,
        OP_ADD_HEAD = 3'd1,
        OP_ADD_AUTO = 3'd2,
        OP_REMOVE   = 3'd3,
        OP_TICK     = 3'd4,
        OP_PICK     = 3'd5,
        OP_LOCK     = 3'd6,
        OP_UNLOCK   = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_LOCK_OVF    = 3'd1,
        ST_ALREADY_EN  = 3'd2,
        ST_STILL_LOCK  = 3'd3,
        ST_NO_READY    = 3'd4,
        ST_IN_INTR     = 3'd5
    } status_t;
endpackage

### hdl/prqs_ram.sv
// Generic single-port-write, one-read-port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### hdl/priority_ready_queue_scheduler_core.sv
// Top level of the priority ready queue scheduler: sequencer, bitmap and task memories.
// Depends on prqs_pkg and prqs_ram.
//
// Channel | Direction | Handshake         | Payload
// input   | in        | in_valid/in_stall | opcode task_id task_prio round_robin slice_total in_interrupt
// output  | out       | out_valid/out_stall | status picked_task switched highest_prio lock_depth
//
// A result for an operation that touches no memory is registered straight into the output state;
// adds and removes first relink task records through the read and write states. A remove that
// empties the top priority list scans the bitmap one priority a cycle. Reset clears the bitmap,
// lock count and active task at once. The result is held in an output register; the next item is
// taken in the cycle after it has been delivered.
`timescale 1ns / 1ps
module priority_ready_queue_scheduler_core #(
    parameter int TASKS      = 32,
    parameter int PRIORITIES = 32,
    parameter int MAX_LOCK   = 255
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [4:0]  task_id,
    input  logic [4:0]  task_prio,
    input  logic        round_robin,
    input  logic [15:0] slice_total,
    input  logic        in_interrupt,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [4:0]  picked_task,
    output logic        switched,
    output logic [4:0]  highest_prio,
    output logic [7:0]  lock_depth
);
    import prqs_pkg::*;

    localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int PW = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
    localparam int RECW = 2 * TW + PW + 1 + 32;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_RD1   = 11'b00000000010,
        S_EV1   = 11'b00000000100,
        S_RD2   = 11'b00000001000,
        S_EV2   = 11'b00000010000,
        S_RD3   = 11'b00000100000,
        S_EV3   = 11'b00001000000,
        S_WR1   = 11'b00010000000,
        S_WR2   = 11'b00100000000,
        S_SCAN  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    // Task record: next, prev, prio, rr, slice_left, slice_reload.
    typedef struct packed {
        logic [TW-1:0] nxt;
        logic [TW-1:0] prv;
        logic [PW-1:0] prio;
        logic          rr;
        logic [15:0]   left;
        logic [15:0]   reload;
    } rec_t;

    state_t state_reg, state_next;
    logic [PRIORITIES-1:0] bitmap_reg, bitmap_next;
    logic [PW-1:0] top_reg, top_next;
    logic [7:0] lock_reg, lock_next;
    logic [TW-1:0] active_reg, active_next;
    logic out_valid_reg, out_valid_next;
    logic [2:0] status_reg, status_next;
    logic sw_reg, sw_next;

    opcode_t op_reg, op_next;
    logic [TW-1:0] t_reg, t_next;
    logic [PW-1:0] p_reg, p_next;
    logic rr_reg, rr_next;
    logic [15:0] st_reg, st_next;
    logic [PW-1:0] hp_reg, hp_next;       // working priority
    logic [TW-1:0] h_reg, h_next;         // list head
    rec_t ra_reg, ra_next;                // first record held
    rec_t rb_reg, rb_next;                // second record held
    logic head_reg, head_next;
    logic [PW-1:0] scan_reg, scan_next;

    logic          rec_we;
    logic [TW-1:0] rec_waddr, rec_raddr;
    rec_t          rec_wdata, rec_rdata;
    logic [RECW-1:0] rec_rbits;
    logic          lh_we;
    logic [PW-1:0] lh_waddr, lh_raddr;
    logic [TW-1:0] lh_wdata, lh_rdata;

    prqs_ram #(.WIDTH(RECW), .DEPTH(TASKS)) u_rec (
        .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_rbits)
    );
    assign rec_rdata = rec_t'(rec_rbits);

    prqs_ram #(.WIDTH(TW), .DEPTH(PRIORITIES)) u_head (
        .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(lh_raddr), .rdata(lh_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bitmap_reg    <= '0;
            top_reg       <= PW'(PRIORITIES - 1);
            lock_reg      <= '0;
            active_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bitmap_reg    <= bitmap_next;
            top_reg       <= top_next;
            lock_reg      <= lock_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        sw_reg     <= sw_next;
        op_reg     <= op_next;
        t_reg      <= t_next;
        p_reg      <= p_next;
        rr_reg     <= rr_next;
        st_reg     <= st_next;
        hp_reg     <= hp_next;
        h_reg      <= h_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        head_reg   <= head_next;
        scan_reg   <= scan_next;
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign picked_task  = 5'(active_reg);
    assign switched     = sw_reg;
    assign highest_prio = 5'(top_reg);
    assign lock_depth   = lock_reg;

    always_comb
    begin
        state_next     = state_reg;
        bitmap_next    = bitmap_reg;
        top_next       = top_reg;
        lock_next      = lock_reg;
        active_next    = active_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        sw_next        = sw_reg;
        op_next        = op_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        rr_next        = rr_reg;
        st_next        = st_reg;
        hp_next        = hp_reg;
        h_next         = h_reg;
        ra_next        = ra_reg;
        rb_next        = rb_reg;
        head_next      = head_reg;
        scan_next      = scan_reg;
        rec_we         = 1'b0;
        rec_waddr      = t_reg;
        rec_wdata      = ra_reg;
        rec_raddr      = active_reg;
        lh_we          = 1'b0;
        lh_waddr       = hp_reg;
        lh_wdata       = t_reg;
        lh_raddr       = top_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = opcode_t'(opcode);
                    t_next      = TW'(task_id);
                    p_next      = PW'(task_prio);
                    rr_next     = round_robin;
                    st_next     = slice_total;
                    status_next = ST_OK;
                    sw_next     = 1'b0;
                    state_next  = S_OUT;
                    case (opcode_t'(opcode))
                        OP_ADD_TAIL, OP_ADD_HEAD, OP_ADD_AUTO:
                        begin
                            if (32'(task_id) < TASKS && 32'(task_prio) < PRIORITIES)
                            begin
                                rec_raddr  = active_reg;
                                lh_raddr   = PW'(task_prio);
                                hp_next    = PW'(task_prio);
                                state_next = S_RD1;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (32'(task_id) < TASKS)
                            begin
                                rec_raddr  = TW'(task_id);
                                state_next = S_RD1;
                            end
                        end
                        OP_TICK:
                        begin
                            rec_raddr  = active_reg;
                            state_next = S_RD1;
                        end
                        OP_PICK:
                        begin
                            if (in_interrupt)
                                status_next = ST_IN_INTR;
                            else if (lock_reg != 8'd0)
                                status_next = ST_STILL_LOCK;
                            else if (!bitmap_reg[top_reg])
                                status_next = ST_NO_READY;
                            else
                            begin
                                lh_raddr   = top_reg;
                                state_next = S_RD1;
                            end
                        end
                        OP_LOCK:
                        begin
                            if (in_interrupt)
                                status_next = ST_IN_INTR;
                            else if (32'(lock_reg) >= MAX_LOCK)
                                status_next = ST_LOCK_OVF;
                            else
                                lock_next = lock_reg + 8'd1;
                        end
                        default:
                        begin
                            if (in_interrupt)
                                status_next = ST_IN_INTR;
                            else if (lock_reg == 8'd0)
                                status_next = ST_ALREADY_EN;
                            else
                            begin
                                lock_next = lock_reg - 8'd1;
                                if (lock_reg != 8'd1)
                                    status_next = ST_STILL_LOCK;
                                else if (bitmap_reg[top_reg])
                                begin
                                    lh_raddr   = top_reg;
                                    state_next = S_RD1;
                                end
                            end
                        end
                    endcase
                end
            end
            S_RD1:
            begin
                state_next = S_EV1;
                case (op_reg)
                    OP_ADD_TAIL, OP_ADD_HEAD, OP_ADD_AUTO:
                    begin
                        // Record of the active task and the list head are now valid.
                        if (op_reg == OP_ADD_AUTO)
                            head_next = (rec_rdata.prio == p_reg);
                        else
                            head_next = (op_reg == OP_ADD_HEAD);
                        h_next = lh_rdata;
                        if (!bitmap_reg[p_reg])
                        begin
                            ra_next = '{nxt: t_reg, prv: t_reg, prio: p_reg, rr: rr_reg,
                                        left: st_reg, reload: st_reg};
                            rec_we      = 1'b1;
                            rec_waddr   = t_reg;
                            rec_wdata   = '{nxt: t_reg, prv: t_reg, prio: p_reg, rr: rr_reg,
                                            left: st_reg, reload: st_reg};
                            lh_we       = 1'b1;
                            lh_waddr    = p_reg;
                            lh_wdata    = t_reg;
                            bitmap_next[p_reg] = 1'b1;
                            if (p_reg < top_reg)
                                top_next = p_reg;
                            state_next  = S_OUT;
                        end
                        else
                        begin
                            rec_raddr = lh_rdata;
                        end
                    end
                    OP_REMOVE, OP_TICK:
                    begin
                        ra_next  = rec_rdata;
                        hp_next  = rec_rdata.prio;
                        lh_raddr = rec_rdata.prio;
                        if (32'(rec_rdata.prio) >= PRIORITIES || !bitmap_reg[rec_rdata.prio]
                            || (op_reg == OP_TICK && !rec_rdata.rr))
                            state_next = S_OUT;
                    end
                    default:
                    begin
                        if (lh_rdata != active_reg)
                        begin
                            active_next = lh_rdata;
                            sw_next     = 1'b1;
                        end
                        state_next = S_OUT;
                    end
                endcase
            end
            S_EV1:
            begin
                case (op_reg)
                    OP_ADD_TAIL, OP_ADD_HEAD, OP_ADD_AUTO:
                    begin
                        // Head record read; tail = head.prv.
                        rb_next   = rec_rdata;
                        rec_raddr = rec_rdata.prv;
                        state_next = S_RD2;
                    end
                    default:
                    begin
                        h_next    = lh_rdata;
                        rec_raddr = lh_rdata;
                        state_next = S_RD2;
                    end
                endcase
            end
            S_RD2:
            begin
                state_next = S_EV2;
                case (op_reg)
                    OP_ADD_TAIL, OP_ADD_HEAD, OP_ADD_AUTO:
                    begin
                        // Tail record valid. Write tail.nxt = t.
                        ra_next   = rec_rdata;
                        rec_we    = 1'b1;
                        rec_waddr = rb_reg.prv;
                        rec_wdata = rec_rdata;
                        rec_wdata.nxt = t_reg;
                        if (rb_reg.prv == h_reg)
                        begin
                            rec_wdata.prv = t_reg;
                        end
                    end
                    OP_REMOVE:
                    begin
                        rb_next = rec_rdata;
                        if (rec_rdata.nxt == h_reg)
                        begin
                            bitmap_next[hp_reg] = 1'b0;
                            if (hp_reg != top_reg)
                                state_next = S_OUT;
                            else
                            begin
                                scan_next  = '0;
                                state_next = S_SCAN;
                            end
                        end
                        else
                        begin
                            if (h_reg == t_reg)
                            begin
                                lh_we    = 1'b1;
                                lh_waddr = hp_reg;
                                lh_wdata = ra_reg.nxt;
                            end
                            rec_raddr = ra_reg.prv;
                        end
                    end
                    default:
                    begin
                        if (rec_rdata.nxt == h_reg)
                            state_next = S_OUT;
                        else
                        begin
                            rec_raddr = active_reg;
                            rb_next   = rec_rdata;
                        end
                    end
                endcase
            end
            S_EV2:
            begin
                case (op_reg)
                    OP_ADD_TAIL, OP_ADD_HEAD, OP_ADD_AUTO:
                    begin
                        // Head prv = t (when head differs from tail).
                        if (ra_reg.nxt != t_reg && rb_reg.prv != h_reg)
                        begin
                            rec_we    = 1'b1;
                            rec_waddr = h_reg;
                            rec_wdata = rb_reg;
                            rec_wdata.prv = t_reg;
                        end
                        state_next = S_WR1;
                    end
                    OP_REMOVE:
                    begin
                        // Prev record read: prv.nxt = t.nxt.
                        rec_we    = 1'b1;
                        rec_waddr = ra_reg.prv;
                        rec_wdata = rec_rdata;
                        rec_wdata.nxt = ra_reg.nxt;
                        if (ra_reg.prv == ra_reg.nxt)
                            rec_wdata.prv = ra_reg.prv;
                        rec_raddr  = ra_reg.nxt;
                        state_next = S_RD3;
                    end
                    default:
                    begin
                        // Active record re-read is the same as ra_reg.
                        if (ra_reg.left > 16'd1)
                        begin
                            rec_we    = 1'b1;
                            rec_waddr = active_reg;
                            rec_wdata = ra_reg;
                            rec_wdata.left = ra_reg.left - 16'd1;
                        end
                        else
                        begin
                            lh_we    = 1'b1;
                            lh_waddr = hp_reg;
                            lh_wdata = rb_reg.nxt;
                            rec_we    = 1'b1;
                            rec_waddr = active_reg;
                            rec_wdata = ra_reg;
                            rec_wdata.left = ra_reg.reload;
                        end
                        state_next = S_OUT;
                    end
                endcase
            end
            S_RD3:
            begin
                rec_raddr  = ra_reg.nxt;
                state_next = S_EV3;
            end
            S_EV3:
            begin
                // Next record read (after the prev write): nxt.prv = t.prv.
                if (ra_reg.prv != ra_reg.nxt)
                begin
                    rec_we    = 1'b1;
                    rec_waddr = ra_reg.nxt;
                    rec_wdata = rec_rdata;
                    rec_wdata.prv = ra_reg.prv;
                end
                state_next = S_OUT;
            end
            S_WR1:
            begin
                rec_we    = 1'b1;
                rec_waddr = t_reg;
                rec_wdata = '{nxt: h_reg, prv: rb_reg.prv, prio: p_reg, rr: rr_reg,
                              left: st_reg, reload: st_reg};
                if (head_reg)
                begin
                    lh_we    = 1'b1;
                    lh_waddr = p_reg;
                    lh_wdata = t_reg;
                end
                state_next = S_WR2;
            end
            S_WR2:
            begin
                state_next = S_OUT;
            end
            S_SCAN:
            begin
                if (bitmap_reg[scan_reg])
                begin
                    top_next   = scan_reg;
                    state_next = S_OUT;
                end
                else if (32'(scan_reg) == PRIORITIES - 1)
                begin
                    top_next    = PW'(PRIORITIES - 1);
                    status_next = ST_NO_READY;
                    state_next  = S_OUT;
                end
                else
                    scan_next = scan_reg + PW'(1);
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                    out_valid_next = 1'b1;
                else if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result shown outside the output state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> !out_valid)
        else $error("result appeared in the cycle after a transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(status))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(lock_reg) <= MAX_LOCK)
        else $error("lock count above its limit");
endmodule
